@@ sv/ted_pkg.sv @@
package ted_pkg;

    // Display command codes
    localparam logic [4:0] CMD_PRINT       = 5'd0;
    localparam logic [4:0] CMD_BS          = 5'd1;
    localparam logic [4:0] CMD_TAB         = 5'd2;
    localparam logic [4:0] CMD_LF          = 5'd3;
    localparam logic [4:0] CMD_CR          = 5'd4;
    localparam logic [4:0] CMD_LEFT        = 5'd5;
    localparam logic [4:0] CMD_DOWN        = 5'd6;
    localparam logic [4:0] CMD_RIGHT       = 5'd7;
    localparam logic [4:0] CMD_UP          = 5'd8;
    localparam logic [4:0] CMD_POS         = 5'd9;
    localparam logic [4:0] CMD_ERASE_FWD   = 5'd10;
    localparam logic [4:0] CMD_ERASE_ALL   = 5'd11;
    localparam logic [4:0] CMD_ERASE_LINE  = 5'd12;
    localparam logic [4:0] CMD_SHOW_CUR    = 5'd13;
    localparam logic [4:0] CMD_HIDE_CUR    = 5'd14;
    localparam logic [4:0] CMD_SGR_RESET   = 5'd15;
    localparam logic [4:0] CMD_BOLD        = 5'd16;
    localparam logic [4:0] CMD_ITALIC      = 5'd17;
    localparam logic [4:0] CMD_UNDERLINE   = 5'd18;
    localparam logic [4:0] CMD_BOLD_OFF    = 5'd19;
    localparam logic [4:0] CMD_ITALIC_OFF  = 5'd20;
    localparam logic [4:0] CMD_UNDER_OFF   = 5'd21;
    localparam logic [4:0] CMD_FG_COLOUR   = 5'd22;
    localparam logic [4:0] CMD_FG_DEFAULT  = 5'd23;
    localparam logic [4:0] CMD_BG_COLOUR   = 5'd24;
    localparam logic [4:0] CMD_BG_DEFAULT  = 5'd25;
    localparam logic [4:0] CMD_TITLE_BYTE  = 5'd26;
    localparam logic [4:0] CMD_TITLE_END   = 5'd27;
    localparam logic [4:0] CMD_UNHANDLED   = 5'd28;

    // At most this many results come from one byte
    localparam int MAX_RESULTS = 3;

    localparam logic [7:0] CHAR_SGR = 8'h6D;

    // One queued job: a single ready command, or an SGR list to expand
    typedef struct packed {
        logic        is_sgr;
        logic [4:0]  command;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
        logic [7:0]  text_byte;
    } ted_entry_t;

endpackage

@@ sv/ted_front.sv @@
module ted_front #(
    parameter int MAX_PARAMS  = 3,
    parameter int PARAM_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [7:0]                        byte_in,
    output logic                              push,
    output ted_pkg::ted_entry_t               push_entry,
    output logic [MAX_PARAMS*PARAM_WIDTH-1:0] push_params,
    output logic [MAX_PARAMS-1:0]             push_present
);
    import ted_pkg::*;

    localparam int IDX_W   = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int COL_IDX = (MAX_PARAMS > 1) ? 1 : 0;
    localparam int EXT_W   = PARAM_WIDTH + 16;

    // Parser states
    localparam logic [2:0] M_GROUND    = 3'd0;
    localparam logic [2:0] M_ESC       = 3'd1;
    localparam logic [2:0] M_CSI_START = 3'd2;
    localparam logic [2:0] M_CSI_BODY  = 3'd3;
    localparam logic [2:0] M_OSC_START = 3'd4;
    localparam logic [2:0] M_OSC_NUM   = 3'd5;
    localparam logic [2:0] M_OSC_TEXT  = 3'd6;

    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_BEL  = 8'h07;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_RBR  = 8'h5D;
    localparam logic [7:0] CH_QM   = 8'h3F;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_J    = 8'h4A;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_LH   = 8'h68;
    localparam logic [7:0] CH_LL   = 8'h6C;

    logic [2:0]             mode_reg, mode_next;
    logic                   priv_reg, priv_next;
    logic [PARAM_WIDTH-1:0] param_reg  [MAX_PARAMS];
    logic [PARAM_WIDTH-1:0] param_next [MAX_PARAMS];
    logic [MAX_PARAMS-1:0]  present_reg, present_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [15:0]            osc_num_reg, osc_num_next;
    logic [1:0]             osc_tgt_reg, osc_tgt_next;

    logic                   is_digit;
    logic [3:0]             digit;
    logic [PARAM_WIDTH+3:0] par_mul;
    logic [PARAM_WIDTH-1:0] par_sat;
    logic [19:0]            osc_mul;
    logic [15:0]            osc_sat;
    logic [PARAM_WIDTH-1:0] p0;
    logic [PARAM_WIDTH-1:0] p_col;
    logic [EXT_W-1:0]       p0_ext;
    logic [EXT_W-1:0]       col_ext;
    logic                   slot_room;
    ted_entry_t             ent;
    logic                   emit;

    assign is_digit = (byte_in >= CH_0) && (byte_in <= CH_9);
    assign digit    = byte_in[3:0];

    // Decimal accumulate with saturation, parameter of the current slot
    assign par_mul = ({4'b0, param_reg[slot_reg]} << 3)
                   + ({4'b0, param_reg[slot_reg]} << 1)
                   + {{PARAM_WIDTH{1'b0}}, digit};
    assign par_sat = (par_mul[PARAM_WIDTH+3:PARAM_WIDTH] != 4'b0)
                   ? {PARAM_WIDTH{1'b1}} : par_mul[PARAM_WIDTH-1:0];

    assign osc_mul = ({4'b0, osc_num_reg} << 3) + ({4'b0, osc_num_reg} << 1)
                   + {16'b0, digit};
    assign osc_sat = (osc_mul[19:16] != 4'b0) ? 16'hFFFF : osc_mul[15:0];

    assign p0      = param_reg[0];
    assign p_col   = (MAX_PARAMS > 1) ? param_reg[COL_IDX] : '0;
    assign p0_ext  = {16'b0, p0};
    assign col_ext = {16'b0, p_col};

    assign slot_room = ({1'b0, slot_reg} + 1'b1) < (IDX_W+1)'(MAX_PARAMS);

    // Next state and the job for this byte
    always_comb
    begin
        mode_next    = mode_reg;
        priv_next    = priv_reg;
        param_next   = param_reg;
        present_next = present_reg;
        slot_next    = slot_reg;
        osc_num_next = osc_num_reg;
        osc_tgt_next = osc_tgt_reg;
        emit         = 1'b0;
        ent          = '0;

        case (mode_reg)
            M_ESC:
            begin
                if (byte_in == CH_LBR)
                begin
                    mode_next    = M_CSI_START;
                    priv_next    = 1'b0;
                    for (int i = 0; i < MAX_PARAMS; i++)
                    begin
                        param_next[i] = '0;
                    end
                    present_next = '0;
                    slot_next    = '0;
                end
                else if (byte_in == CH_RBR)
                begin
                    mode_next    = M_OSC_START;
                    osc_num_next = '0;
                    osc_tgt_next = '0;
                end
                else
                begin
                    mode_next     = M_GROUND;
                    emit          = 1'b1;
                    ent.command   = CMD_UNHANDLED;
                    ent.text_byte = byte_in;
                end
            end
            M_CSI_START, M_CSI_BODY:
            begin
                if (mode_reg == M_CSI_START && byte_in == CH_QM)
                begin
                    priv_next = 1'b1;
                    mode_next = M_CSI_BODY;
                end
                else if (is_digit)
                begin
                    param_next[slot_reg]   = par_sat;
                    present_next[slot_reg] = 1'b1;
                    mode_next              = M_CSI_BODY;
                end
                else if (byte_in == CH_SEMI)
                begin
                    if (slot_room)
                    begin
                        slot_next = slot_reg + 1'b1;
                        mode_next = M_CSI_BODY;
                    end
                    else
                    begin
                        mode_next     = M_GROUND;
                        emit          = 1'b1;
                        ent.command   = CMD_UNHANDLED;
                        ent.text_byte = byte_in;
                    end
                end
                else
                begin
                    // Final byte
                    mode_next     = M_GROUND;
                    emit          = 1'b1;
                    ent.command   = CMD_UNHANDLED;
                    ent.text_byte = byte_in;
                    case (byte_in)
                        CH_D:
                        begin
                            ent = '0;
                            ent.command = CMD_LEFT;
                        end
                        CH_B:
                        begin
                            ent = '0;
                            ent.command = CMD_DOWN;
                        end
                        CH_C:
                        begin
                            ent = '0;
                            ent.command = CMD_RIGHT;
                        end
                        CH_A:
                        begin
                            ent = '0;
                            ent.command = CMD_UP;
                        end
                        CH_H:
                        begin
                            ent = '0;
                            ent.command = CMD_POS;
                            ent.arg_a   = p0_ext[15:0];
                            ent.arg_b   = col_ext[15:0];
                        end
                        CH_J:
                        begin
                            if (p0_ext == '0)
                            begin
                                ent = '0;
                                ent.command = CMD_ERASE_FWD;
                            end
                            else if (p0_ext == EXT_W'(2))
                            begin
                                ent = '0;
                                ent.command = CMD_ERASE_ALL;
                            end
                        end
                        CH_K:
                        begin
                            if (p0_ext == '0)
                            begin
                                ent = '0;
                                ent.command = CMD_ERASE_LINE;
                            end
                        end
                        CH_LH:
                        begin
                            if (priv_reg && present_reg[0] && p0_ext == EXT_W'(25))
                            begin
                                ent = '0;
                                ent.command = CMD_SHOW_CUR;
                            end
                        end
                        CH_LL:
                        begin
                            if (priv_reg && present_reg[0] && p0_ext == EXT_W'(25))
                            begin
                                ent = '0;
                                ent.command = CMD_HIDE_CUR;
                            end
                        end
                        CHAR_SGR:
                        begin
                            ent = '0;
                            ent.is_sgr = 1'b1;
                        end
                        default:
                        begin
                            ent.command = CMD_UNHANDLED;
                        end
                    endcase
                end
            end
            M_OSC_START, M_OSC_NUM:
            begin
                if (is_digit)
                begin
                    osc_num_next = osc_sat;
                    mode_next    = M_OSC_NUM;
                end
                else if (mode_reg == M_OSC_NUM && byte_in == CH_SEMI
                         && osc_num_reg <= 16'd2)
                begin
                    osc_tgt_next = (osc_num_reg == 16'd0) ? 2'd3 : osc_num_reg[1:0];
                    mode_next    = M_OSC_TEXT;
                end
                else
                begin
                    mode_next     = M_GROUND;
                    emit          = 1'b1;
                    ent.command   = CMD_UNHANDLED;
                    ent.text_byte = byte_in;
                end
            end
            M_OSC_TEXT:
            begin
                emit      = 1'b1;
                ent.arg_a = {14'b0, osc_tgt_reg};
                if (byte_in == CH_BEL)
                begin
                    mode_next   = M_GROUND;
                    ent.command = CMD_TITLE_END;
                end
                else
                begin
                    ent.command   = CMD_TITLE_BYTE;
                    ent.text_byte = byte_in;
                end
            end
            default:
            begin
                mode_next = M_GROUND;
                emit      = 1'b1;
                if (byte_in == CH_BS)
                begin
                    ent.command = CMD_BS;
                end
                else if (byte_in == CH_TAB)
                begin
                    ent.command = CMD_TAB;
                end
                else if (byte_in >= CH_LF && byte_in <= CH_FF)
                begin
                    ent.command = CMD_LF;
                end
                else if (byte_in == CH_CR)
                begin
                    ent.command = CMD_CR;
                end
                else if (byte_in == CH_ESC)
                begin
                    emit      = 1'b0;
                    mode_next = M_ESC;
                end
                else if (byte_in < CH_SP || byte_in == CH_DEL)
                begin
                    emit = 1'b0;
                end
                else
                begin
                    ent.command   = CMD_PRINT;
                    ent.text_byte = byte_in;
                end
            end
        endcase
    end

    assign push       = accept && emit;
    assign push_entry = ent;

    // SGR jobs carry the parameter set as it stands at the final byte
    always_comb
    begin
        for (int i = 0; i < MAX_PARAMS; i++)
        begin
            push_params[i*PARAM_WIDTH +: PARAM_WIDTH] = param_reg[i];
        end
    end
    assign push_present = present_reg;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_GROUND;
            priv_reg    <= 1'b0;
            present_reg <= '0;
            slot_reg    <= '0;
            osc_num_reg <= '0;
            osc_tgt_reg <= '0;
            for (int i = 0; i < MAX_PARAMS; i++)
            begin
                param_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            priv_reg    <= priv_next;
            present_reg <= present_next;
            slot_reg    <= slot_next;
            osc_num_reg <= osc_num_next;
            osc_tgt_reg <= osc_tgt_next;
            param_reg   <= param_next;
        end
    end

endmodule

@@ sv/ted_queue.sv @@
module ted_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/ted_back.sv @@
module ted_back #(
    parameter int MAX_PARAMS  = 3,
    parameter int PARAM_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  ted_pkg::ted_entry_t               head_entry,
    input  logic [MAX_PARAMS*PARAM_WIDTH-1:0] head_params,
    input  logic [MAX_PARAMS-1:0]             head_present,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [4:0]                        command,
    output logic [15:0]                       arg_a,
    output logic [15:0]                       arg_b,
    output logic [7:0]                        text_byte,
    output logic                              last
);
    import ted_pkg::*;

    localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int EXT_W = PARAM_WIDTH + 16;

    logic                   walk_reg, walk_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [MAX_PARAMS-1:0]  rem_reg, rem_next;
    logic [1:0]             cnt_reg, cnt_next;

    logic [IDX_W-1:0]       cur_idx;
    logic [MAX_PARAMS-1:0]  cur_rem;
    logic [1:0]             cur_cnt;
    logic [IDX_W-1:0]       low_idx;
    logic [PARAM_WIDTH-1:0] cur_val;
    logic [EXT_W-1:0]       v_ext;
    logic [EXT_W-1:0]       v_sub;
    logic                   sgr_last;
    logic [4:0]             sgr_cmd;
    logic [15:0]            sgr_arg;
    logic                   fire;

    // SGR walk: slot 0 always, then each present slot, at most three results
    assign cur_idx  = walk_reg ? idx_reg : '0;
    assign cur_rem  = walk_reg ? rem_reg : (head_present & ~MAX_PARAMS'(1));
    assign cur_cnt  = walk_reg ? cnt_reg : 2'd0;
    assign sgr_last = (cur_rem == '0) || (cur_cnt == 2'(MAX_RESULTS - 1));

    always_comb
    begin
        low_idx = '0;
        for (int i = MAX_PARAMS - 1; i >= 0; i--)
        begin
            if (cur_rem[i])
            begin
                low_idx = IDX_W'(i);
            end
        end
    end

    assign cur_val = head_params[cur_idx*PARAM_WIDTH +: PARAM_WIDTH];
    assign v_ext   = {16'b0, cur_val};

    // Decode one SGR value
    always_comb
    begin
        sgr_arg = '0;
        if (v_ext >= EXT_W'(40))
        begin
            v_sub = v_ext - EXT_W'(40);
        end
        else
        begin
            v_sub = v_ext - EXT_W'(30);
        end
        if (v_ext == EXT_W'(0))
        begin
            sgr_cmd = CMD_SGR_RESET;
        end
        else if (v_ext == EXT_W'(1))
        begin
            sgr_cmd = CMD_BOLD;
        end
        else if (v_ext == EXT_W'(3))
        begin
            sgr_cmd = CMD_ITALIC;
        end
        else if (v_ext == EXT_W'(4))
        begin
            sgr_cmd = CMD_UNDERLINE;
        end
        else if (v_ext == EXT_W'(22))
        begin
            sgr_cmd = CMD_BOLD_OFF;
        end
        else if (v_ext == EXT_W'(23))
        begin
            sgr_cmd = CMD_ITALIC_OFF;
        end
        else if (v_ext == EXT_W'(24))
        begin
            sgr_cmd = CMD_UNDER_OFF;
        end
        else if (v_ext >= EXT_W'(30) && v_ext <= EXT_W'(37))
        begin
            sgr_cmd = CMD_FG_COLOUR;
            sgr_arg = {13'b0, v_sub[2:0]};
        end
        else if (v_ext == EXT_W'(39))
        begin
            sgr_cmd = CMD_FG_DEFAULT;
        end
        else if (v_ext >= EXT_W'(40) && v_ext <= EXT_W'(47))
        begin
            sgr_cmd = CMD_BG_COLOUR;
            sgr_arg = {13'b0, v_sub[2:0]};
        end
        else if (v_ext == EXT_W'(49))
        begin
            sgr_cmd = CMD_BG_DEFAULT;
        end
        else
        begin
            sgr_cmd = CMD_UNHANDLED;
        end
    end

    // Result fields
    always_comb
    begin
        if (head_entry.is_sgr)
        begin
            command   = sgr_cmd;
            arg_a     = sgr_arg;
            arg_b     = '0;
            text_byte = (sgr_cmd == CMD_UNHANDLED) ? CHAR_SGR : 8'h00;
            last      = sgr_last;
        end
        else
        begin
            command   = head_entry.command;
            arg_a     = head_entry.arg_a;
            arg_b     = head_entry.arg_b;
            text_byte = head_entry.text_byte;
            last      = 1'b1;
        end
    end

    assign out_valid = head_valid;
    assign fire      = head_valid && out_ready;
    assign pop       = fire && last;

    // Walk state update
    always_comb
    begin
        walk_next = walk_reg;
        idx_next  = idx_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (pop)
        begin
            walk_next = 1'b0;
        end
        else if (fire)
        begin
            walk_next = 1'b1;
            idx_next  = low_idx;
            rem_next  = cur_rem & (cur_rem - 1'b1);
            cnt_next  = cur_cnt + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg <= 1'b0;
            idx_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            walk_reg <= walk_next;
            idx_reg  <= idx_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

@@ sv/terminal_escape_decoder_unit.sv @@
// Channel | Signals                          | Item
// s       | s_tvalid s_tready s_tdata        | one terminal byte
// m       | m_tvalid m_tready m_tdata m_tlast| one display command
//
// One byte is taken per cycle; the parser updates its state as it takes it.
// Each byte makes at most one queued job, and the emitter puts out one result
// per cycle from the head job; an SGR job with k results stays until the last.
// s_tready drops only while the job queue (QUEUE_DEPTH entries) is full.
// m_tready low holds the current result; reset returns the parser to ground
// and empties the queue, with no clearing pass.
module terminal_escape_decoder_unit #(
    parameter int MAX_PARAMS  = 3,
    parameter int PARAM_WIDTH = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [4:0] command, [20:5] arg_a, [36:21] arg_b,
                                   // [44:37] text_byte, [47:45] zero
    output logic        m_tlast
);
    import ted_pkg::*;

    localparam int PV_W = MAX_PARAMS * PARAM_WIDTH;
    localparam int EN_W = $bits(ted_entry_t);
    localparam int Q_W  = EN_W + PV_W + MAX_PARAMS;

    logic                  accept;
    logic                  push;
    ted_entry_t            push_entry;
    logic [PV_W-1:0]       push_params;
    logic [MAX_PARAMS-1:0] push_present;
    logic                  q_full;
    logic                  q_empty;
    logic                  pop;
    logic [Q_W-1:0]        q_head;
    ted_entry_t            head_entry;
    logic [PV_W-1:0]       head_params;
    logic [MAX_PARAMS-1:0] head_present;
    logic [4:0]            command;
    logic [15:0]           arg_a;
    logic [15:0]           arg_b;
    logic [7:0]            text_byte;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    // Front: parse and classify
    ted_front #(
        .MAX_PARAMS  (MAX_PARAMS),
        .PARAM_WIDTH (PARAM_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .byte_in      (s_tdata),
        .push         (push),
        .push_entry   (push_entry),
        .push_params  (push_params),
        .push_present (push_present)
    );

    // Job queue between the two sides
    ted_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_present, push_params, push_entry}),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_head),
        .empty     (q_empty)
    );

    assign head_entry   = q_head[EN_W-1:0];
    assign head_params  = q_head[EN_W+PV_W-1:EN_W];
    assign head_present = q_head[Q_W-1:EN_W+PV_W];

    // Back: expand jobs into results
    ted_back #(
        .MAX_PARAMS  (MAX_PARAMS),
        .PARAM_WIDTH (PARAM_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (!q_empty),
        .head_entry   (head_entry),
        .head_params  (head_params),
        .head_present (head_present),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .command      (command),
        .arg_a        (arg_a),
        .arg_b        (arg_b),
        .text_byte    (text_byte),
        .last         (m_tlast)
    );

    assign m_tdata = {3'b000, text_byte, arg_b, arg_a, command};

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import ted_pkg::*;

    // Input byte values the parser reacts to
    localparam logic [7:0] CH_BEL     = 8'h07;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CH_LBRACK  = "[";
    localparam logic [7:0] CH_RBRACK  = "]";
    localparam logic [7:0] CH_QMARK   = "?";
    localparam logic [7:0] CH_SEMI    = ";";
    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_NINE    = "9";

    // CSI final bytes
    localparam logic [7:0] FIN_UP     = "A";
    localparam logic [7:0] FIN_DOWN   = "B";
    localparam logic [7:0] FIN_RIGHT  = "C";
    localparam logic [7:0] FIN_LEFT   = "D";
    localparam logic [7:0] FIN_POS    = "H";
    localparam logic [7:0] FIN_ERASE  = "J";
    localparam logic [7:0] FIN_ELINE  = "K";
    localparam logic [7:0] FIN_SET    = "h";
    localparam logic [7:0] FIN_RESET  = "l";

    // SGR parameter values
    localparam int SGR_V_RESET     = 0;
    localparam int SGR_V_BOLD      = 1;
    localparam int SGR_V_ITALIC    = 3;
    localparam int SGR_V_UNDER     = 4;
    localparam int SGR_V_BOLD_OFF  = 22;
    localparam int SGR_V_ITAL_OFF  = 23;
    localparam int SGR_V_UNDER_OFF = 24;
    localparam int SGR_V_FG_BASE   = 30;
    localparam int SGR_V_FG_DEF    = 39;
    localparam int SGR_V_BG_BASE   = 40;
    localparam int SGR_V_BG_DEF    = 49;
    localparam int CURSOR_MODE     = 25;

    localparam int N_SLOTS        = 3;
    localparam logic [15:0] SAT   = 16'hFFFF;
    localparam int N_RANDOM       = 340;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;

    typedef enum logic [2:0] {
        PS_GROUND,
        PS_ESC,
        PS_CSI_START,
        PS_CSI_BODY,
        PS_OSC_START,
        PS_OSC_NUM,
        PS_OSC_TEXT
    } parse_state_t;

    typedef struct packed {
        logic [4:0]  command;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
        logic [7:0]  text_byte;
        logic        last;
    } disp_cmd_t;

    typedef struct {
        logic [7:0] data;
        bit         hold;
    } tx_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    terminal_escape_decoder_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Shadow parser state
    parse_state_t pmode = PS_GROUND;
    logic         priv_seen = 1'b0;
    logic [15:0]  csi_val [N_SLOTS] = '{default: 16'h0000};
    logic [2:0]   csi_have = 3'b000;
    logic [1:0]   csi_slot = 2'd0;
    logic [15:0]  osc_val = 16'h0000;
    logic [1:0]   osc_mask = 2'd0;

    disp_cmd_t burst [$];
    disp_cmd_t cmds_due [$];
    tx_item_t  tx_q [$];

    int n_errors = 0;
    int n_accepted = 0;
    int stall_cycles = 0;
    bit calm;

    int sgr_pool [24] = '{0, 1, 3, 4, 22, 23, 24, 30, 31, 33, 35, 37,
                          39, 40, 42, 44, 47, 49, 2, 5, 38, 48, 50, 29};

    // One command for the byte in hand; anything past three is dropped
    function automatic void emit(logic [4:0] cmd, logic [15:0] a, logic [15:0] c,
                                 logic [7:0] t);
        if (burst.size() < MAX_RESULTS)
            burst.push_back('{cmd, a, c, t, 1'b0});
    endfunction

    function automatic void emit_sgr(logic [15:0] v);
        if (v == SGR_V_RESET)
            emit(CMD_SGR_RESET, 0, 0, 0);
        else if (v == SGR_V_BOLD)
            emit(CMD_BOLD, 0, 0, 0);
        else if (v == SGR_V_ITALIC)
            emit(CMD_ITALIC, 0, 0, 0);
        else if (v == SGR_V_UNDER)
            emit(CMD_UNDERLINE, 0, 0, 0);
        else if (v == SGR_V_BOLD_OFF)
            emit(CMD_BOLD_OFF, 0, 0, 0);
        else if (v == SGR_V_ITAL_OFF)
            emit(CMD_ITALIC_OFF, 0, 0, 0);
        else if (v == SGR_V_UNDER_OFF)
            emit(CMD_UNDER_OFF, 0, 0, 0);
        else if (v >= SGR_V_FG_BASE && v <= SGR_V_FG_BASE + 7)
            emit(CMD_FG_COLOUR, 16'(v - SGR_V_FG_BASE), 0, 0);
        else if (v == SGR_V_FG_DEF)
            emit(CMD_FG_DEFAULT, 0, 0, 0);
        else if (v >= SGR_V_BG_BASE && v <= SGR_V_BG_BASE + 7)
            emit(CMD_BG_COLOUR, 16'(v - SGR_V_BG_BASE), 0, 0);
        else if (v == SGR_V_BG_DEF)
            emit(CMD_BG_DEFAULT, 0, 0, 0);
        else
            emit(CMD_UNHANDLED, 0, 0, CHAR_SGR);
    endfunction

    // Advance the shadow parser by one byte and queue the commands it causes
    function automatic void decode_byte(logic [7:0] b);
        logic [31:0] acc;
        logic [15:0] p0;
        burst.delete();
        case (pmode)
            PS_ESC:
            begin
                if (b == CH_LBRACK)
                begin
                    pmode = PS_CSI_START;
                    priv_seen = 1'b0;
                    csi_val = '{default: 16'h0000};
                    csi_have = 3'b000;
                    csi_slot = 2'd0;
                end
                else if (b == CH_RBRACK)
                begin
                    pmode = PS_OSC_START;
                    osc_val = 16'h0000;
                    osc_mask = 2'd0;
                end
                else
                begin
                    pmode = PS_GROUND;
                    emit(CMD_UNHANDLED, 0, 0, b);
                end
            end
            PS_CSI_START, PS_CSI_BODY:
            begin
                if (pmode == PS_CSI_START && b == CH_QMARK)
                begin
                    priv_seen = 1'b1;
                    pmode = PS_CSI_BODY;
                end
                else if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    acc = 32'(csi_val[csi_slot]) * 32'd10 + 32'(b - CH_ZERO);
                    csi_val[csi_slot] = (acc > 32'(SAT)) ? SAT : acc[15:0];
                    csi_have[csi_slot] = 1'b1;
                    pmode = PS_CSI_BODY;
                end
                else if (b == CH_SEMI)
                begin
                    if (32'(csi_slot) + 1 < N_SLOTS)
                    begin
                        csi_slot = csi_slot + 2'd1;
                        pmode = PS_CSI_BODY;
                    end
                    else
                    begin
                        pmode = PS_GROUND;
                        emit(CMD_UNHANDLED, 0, 0, b);
                    end
                end
                else
                begin
                    // Final byte: anything else closes the sequence
                    pmode = PS_GROUND;
                    p0 = csi_have[0] ? csi_val[0] : 16'h0000;
                    case (b)
                        FIN_LEFT:  emit(CMD_LEFT, 0, 0, 0);
                        FIN_DOWN:  emit(CMD_DOWN, 0, 0, 0);
                        FIN_RIGHT: emit(CMD_RIGHT, 0, 0, 0);
                        FIN_UP:    emit(CMD_UP, 0, 0, 0);
                        FIN_POS:   emit(CMD_POS, p0, csi_have[1] ? csi_val[1] : 16'h0000, 0);
                        FIN_ERASE:
                        begin
                            if (p0 == 0)
                                emit(CMD_ERASE_FWD, 0, 0, 0);
                            else if (p0 == 2)
                                emit(CMD_ERASE_ALL, 0, 0, 0);
                            else
                                emit(CMD_UNHANDLED, 0, 0, b);
                        end
                        FIN_ELINE:
                        begin
                            if (p0 == 0)
                                emit(CMD_ERASE_LINE, 0, 0, 0);
                            else
                                emit(CMD_UNHANDLED, 0, 0, b);
                        end
                        FIN_SET:
                        begin
                            if (priv_seen && csi_have[0] && p0 == CURSOR_MODE)
                                emit(CMD_SHOW_CUR, 0, 0, 0);
                            else
                                emit(CMD_UNHANDLED, 0, 0, b);
                        end
                        FIN_RESET:
                        begin
                            if (priv_seen && csi_have[0] && p0 == CURSOR_MODE)
                                emit(CMD_HIDE_CUR, 0, 0, 0);
                            else
                                emit(CMD_UNHANDLED, 0, 0, b);
                        end
                        CHAR_SGR:
                        begin
                            emit_sgr(p0);
                            for (int i = 1; i < N_SLOTS; i++)
                                if (csi_have[i])
                                    emit_sgr(csi_val[i]);
                        end
                        default:   emit(CMD_UNHANDLED, 0, 0, b);
                    endcase
                end
            end
            PS_OSC_START, PS_OSC_NUM:
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    acc = 32'(osc_val) * 32'd10 + 32'(b - CH_ZERO);
                    osc_val = (acc > 32'(SAT)) ? SAT : acc[15:0];
                    pmode = PS_OSC_NUM;
                end
                else if (pmode == PS_OSC_NUM && b == CH_SEMI && osc_val <= 2)
                begin
                    osc_mask = (osc_val == 0) ? 2'd3 : osc_val[1:0];
                    pmode = PS_OSC_TEXT;
                end
                else
                begin
                    pmode = PS_GROUND;
                    emit(CMD_UNHANDLED, 0, 0, b);
                end
            end
            PS_OSC_TEXT:
            begin
                // only BEL closes the title, ESC included as text
                if (b == CH_BEL)
                begin
                    pmode = PS_GROUND;
                    emit(CMD_TITLE_END, 16'(osc_mask), 0, 0);
                end
                else
                    emit(CMD_TITLE_BYTE, 16'(osc_mask), 0, b);
            end
            default:
            begin
                pmode = PS_GROUND;
                if (b == CH_BS)
                    emit(CMD_BS, 0, 0, 0);
                else if (b == CH_TAB)
                    emit(CMD_TAB, 0, 0, 0);
                else if (b >= CH_LF && b <= CH_FF)
                    emit(CMD_LF, 0, 0, 0);
                else if (b == CH_CR)
                    emit(CMD_CR, 0, 0, 0);
                else if (b == CH_ESC)
                    pmode = PS_ESC;
                else if (b >= CH_SPACE && b != CH_DEL)
                    emit(CMD_PRINT, 0, 0, b);
            end
        endcase
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            cmds_due.push_back(burst[i]);
    endfunction

    function automatic void add_byte(logic [7:0] b, bit hold = 1'b0);
        tx_q.push_back('{b, hold});
    endfunction

    // Decimal digits of v, now and then with a leading zero
    function automatic void add_num(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(7) == 0)
            add_byte(CH_ZERO);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    // Stimulus, reset and end of run
    initial
    begin
        int n_directed;
        int kind;
        int np;
        int pick;
        logic [7:0] rb;

        // Directed: extremes and the odd corners of the syntax
        add_byte(8'h00);
        add_byte(CH_DEL);
        add_byte(8'h80);
        add_byte(8'hFF);
        add_byte(CH_BS);
        add_byte(CH_TAB);
        add_byte(CH_CR);
        add_byte(CH_ESC);
        add_byte("x");
        add_byte(CH_ESC);
        add_byte(CH_LBRACK);
        add_byte(CH_QMARK);
        add_byte("2");
        add_byte("5");
        add_byte(FIN_RESET);
        add_byte(CH_ESC);
        add_byte(CH_LBRACK);
        add_byte(CH_SEMI);
        add_byte(CH_SEMI);
        add_byte(CH_SEMI);
        add_byte(CH_ESC);
        add_byte(CH_RBRACK);
        add_byte("9");
        add_byte(CH_SEMI);
        add_byte(CH_ESC);
        add_byte(CH_RBRACK);
        add_byte("2");
        add_byte(CH_SEMI);
        add_byte(CH_ESC);
        add_byte(CH_BEL);
        n_directed = tx_q.size();

        // Random: mostly well-formed sequences with random content
        while (tx_q.size() < n_directed + N_RANDOM)
        begin
            kind = $urandom_range(99);
            if (tx_q.size() == n_directed || (tx_q.size() >= 200 && tx_q.size() < 204))
            begin
                // sender waits here until the output has fully drained
                add_byte(8'($urandom_range(32, 126)), 1'b1);
            end
            else if (kind < 14)
                add_byte(8'($urandom_range(255)));
            else if (kind < 22)
            begin
                case ($urandom_range(6))
                    0: add_byte(CH_BS);
                    1: add_byte(CH_TAB);
                    2: add_byte(CH_LF);
                    3: add_byte(8'h0B);
                    4: add_byte(CH_FF);
                    5: add_byte(CH_CR);
                    default: add_byte(8'($urandom_range(31)));
                endcase
            end
            else if (kind < 64)
            begin
                add_byte(CH_ESC);
                add_byte(CH_LBRACK);
                if ($urandom_range(7) == 0)
                begin
                    // cursor show/hide, sometimes malformed
                    if ($urandom_range(3) != 0)
                        add_byte(CH_QMARK);
                    add_num($urandom_range(3) != 0 ? CURSOR_MODE : $urandom_range(20, 30));
                    add_byte($urandom_range(1) ? FIN_SET : FIN_RESET);
                end
                else
                begin
                    if ($urandom_range(3) == 0)
                        add_byte(CH_QMARK);
                    np = ($urandom_range(9) == 0) ? 4 : $urandom_range(3);
                    for (int i = 0; i < np; i++)
                    begin
                        if (i > 0)
                            add_byte(CH_SEMI);
                        pick = $urandom_range(9);
                        if (pick >= 2 && pick <= 4)
                            add_num(sgr_pool[$urandom_range(23)]);
                        else if (pick == 5)
                            add_num($urandom_range(99));
                        else if (pick == 6)
                            add_num($urandom_range(65530, 9999999));
                        else if (pick == 7)
                            add_num($urandom_range(9));
                        else if (pick == 8)
                            add_num(2);
                    end
                    case ($urandom_range(15))
                        0:  add_byte(FIN_UP);
                        1:  add_byte(FIN_DOWN);
                        2:  add_byte(FIN_RIGHT);
                        3:  add_byte(FIN_LEFT);
                        4:  add_byte(FIN_POS);
                        5:  add_byte(FIN_ERASE);
                        6:  add_byte(FIN_ELINE);
                        7:  add_byte(FIN_SET);
                        8:  add_byte(FIN_RESET);
                        13: add_byte(8'($urandom_range(255)));
                        14: add_byte(8'($urandom_range(31)));
                        15: add_byte(8'($urandom_range(8'h40, 8'h7E)));
                        default: add_byte(CHAR_SGR);
                    endcase
                end
            end
            else if (kind < 82)
            begin
                add_byte(CH_ESC);
                add_byte(CH_RBRACK);
                pick = $urandom_range(9);
                if (pick == 0)
                    add_byte(8'($urandom_range(255)));
                else
                begin
                    if (pick == 1)
                        add_num($urandom_range(3, 70000));
                    else
                        add_num($urandom_range(2));
                    add_byte(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : CH_SEMI);
                end
                np = $urandom_range(8);
                for (int i = 0; i < np; i++)
                begin
                    rb = ($urandom_range(9) == 0) ? CH_ESC : 8'($urandom_range(255));
                    add_byte((rb == CH_BEL) ? 8'h47 : rb);
                end
                add_byte(CH_BEL);
            end
            else if (kind < 90)
            begin
                add_byte(CH_ESC);
                add_byte(8'($urandom_range(255)));
            end
            else
            begin
                np = $urandom_range(1, 4);
                for (int i = 0; i < np; i++)
                    add_byte(8'($urandom_range(32, 126)));
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (tx_q.size() != 0 || s_tvalid || cmds_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // No idling over a stretch in the middle of the run
    assign calm = (n_accepted >= 150) && (n_accepted < 230);

    // Byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata);
                n_accepted <= n_accepted + 1;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (tx_q.size() != 0 && !(tx_q[0].hold && cmds_due.size() != 0)
                    && (calm || $urandom_range(99) >= 26))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_q[0].data;
                    tx_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Command monitor
    always @(posedge clk or negedge rst_n)
    begin
        disp_cmd_t got;
        disp_cmd_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[4:0], m_tdata[20:5], m_tdata[36:21], m_tdata[44:37], m_tlast};
                if (cmds_due.size() == 0)
                begin
                    if (n_errors < MAX_REPORTS)
                        $display("%t: unexpected item cmd=%0d a=%0d b=%0d t=%02h last=%0d",
                                 $time, got.command, got.arg_a, got.arg_b, got.text_byte,
                                 got.last);
                    n_errors++;
                end
                else
                begin
                    want = cmds_due.pop_front();
                    if (got != want)
                    begin
                        if (n_errors < MAX_REPORTS)
                            $display({"%t: mismatch exp cmd=%0d a=%0d b=%0d t=%02h last=%0d",
                                      " got cmd=%0d a=%0d b=%0d t=%02h last=%0d"},
                                     $time, want.command, want.arg_a, want.arg_b,
                                     want.text_byte, want.last, got.command, got.arg_a,
                                     got.arg_b, got.text_byte, got.last);
                        n_errors++;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 26);
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
